// File: rtl/core/assert_macros.svh
// Assertion macros shared by the ramp generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_PROP(label, !(expr), msg)

`endif

// File: rtl/core/lrg_pkg.sv
// Shared types, constants and helper functions of the linear ramp generator.
`timescale 1ns / 1ps

package lrg_pkg;

  // Floor of log2, evaluated at elaboration for the per-sample shift.
  function automatic int floor_log2(input int n);
    int s;
    int v;
    s = 0;
    v = n;
    while (v > 1) begin
      v = v >> 1;
      s++;
    end
    return s;
  endfunction

  localparam int BLOCK_SIZE  = 64;
  localparam int BLOCK_SHIFT = floor_log2(BLOCK_SIZE);
  localparam int IDX_W       = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  localparam int LEVEL_W = 32;
  localparam int RAMP_W  = 24;
  localparam int MTT_W   = 24;
  localparam int TICK_W  = 24;
  localparam int PROD_W  = RAMP_W + MTT_W;
  localparam int DIVD_W  = LEVEL_W + 1;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);

  localparam logic [MTT_W-1:0] MS_TO_TICKS_RESET = MTT_W'(1130);

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

  // Request action codes.
  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_STOP = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Signed add saturated to the level width.
  function automatic logic signed [LEVEL_W-1:0] sat_add(
    input logic signed [LEVEL_W-1:0] a,
    input logic signed [LEVEL_W-1:0] b
  );
    logic signed [LEVEL_W:0] sum;
    sum = {a[LEVEL_W-1], a} + {b[LEVEL_W-1], b};
    if (sum[LEVEL_W] != sum[LEVEL_W-1]) begin
      return sum[LEVEL_W] ? LEVEL_MIN : LEVEL_MAX;
    end
    return sum[LEVEL_W-1:0];
  endfunction

endpackage

// File: rtl/core/lrg_channels.sv
// Request and result channel interfaces of the linear ramp generator.
`timescale 1ns / 1ps

interface lrg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic signed [lrg_pkg::LEVEL_W-1:0]   target_value;
  logic [lrg_pkg::RAMP_W-1:0]           ramp_time;

  modport source (output valid, action, target_value, ramp_time, input ready);
  modport sink (input valid, action, target_value, ramp_time, output ready);
endinterface

interface lrg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lrg_pkg::LEVEL_W-1:0]   sample;
  logic                                 last;

  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

// File: rtl/core/lrg_div.sv
// Restoring serial divider: one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrg_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [lrg_pkg::DIVD_W-1:0]      dividend,
  input  logic [lrg_pkg::TICK_W-1:0]      divisor,
  output logic [lrg_pkg::DIVD_W-1:0]      quotient,
  output lrg_pkg::div_stat_t              stat
);

  logic                            busy;
  logic                            done;
  logic [lrg_pkg::DCNT_W-1:0]      cnt;
  logic [lrg_pkg::TICK_W-1:0]      rem;
  logic [lrg_pkg::TICK_W-1:0]      rem_next;
  logic [lrg_pkg::DIVD_W-1:0]      quo;
  logic [lrg_pkg::DIVD_W-1:0]      quo_next;
  logic [lrg_pkg::TICK_W-1:0]      dvs;
  logic [lrg_pkg::TICK_W:0]        trial;
  logic [lrg_pkg::TICK_W:0]        trial_sub;
  logic                            fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial     = {rem, quo[lrg_pkg::DIVD_W-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = (trial >= {1'b0, dvs});
    rem_next  = fits ? trial_sub[lrg_pkg::TICK_W-1:0] : trial[lrg_pkg::TICK_W-1:0];
    quo_next  = {quo[lrg_pkg::DIVD_W-2:0], fits};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lrg_pkg::DCNT_W'(lrg_pkg::DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  `ASSERT_PROP(a_start_busy, start |=> busy, "divider did not start")
  `ASSERT_NEVER(a_done_busy, done && busy, "divider done while still busy")
  `ASSERT_PROP(a_busy_done, $fell(busy) |-> done, "divider stopped without done")

endmodule

// File: rtl/core/linear_ramp_generator.sv
// Top level of the block-rate linear ramp generator.
// Usage: requests arrive on the request channel (valid/ready), each carrying an
// action, a Q16.16 target level and a Q16.8 millisecond ramp time. Set and stop
// requests update the ramp state and produce no result.
// A tick request produces one block of 64 Q16.16 samples on the result channel,
// one per cycle while the receiver is ready, with last high on the final one.
// A tick that follows a set with a non-zero ramp time first resolves the ramp:
// the tick-count multiply, then loading the serial divider, then the divide and
// last storing the steps; the serial divider sets the resolve latency.
// Other ticks go straight to their samples.
// The block takes one request at a time; ready stays low from acceptance of a
// tick until its last sample has been taken. A stalled receiver simply holds
// the current sample and the block waits.
// The ticks-per-millisecond register (Q8.16) is written through cfg_we and cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
// Reset is synchronous and active high; it clears all levels, steps and counts
// to zero and loads the register with its default of 1130.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_ramp_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lrg_pkg::MTT_W-1:0]  cfg_wdata,
  lrg_in_if.sink                     request,
  lrg_out_if.source                  result
);

  lrg_pkg::state_t                      state;
  lrg_pkg::state_t                      state_next;
  logic [lrg_pkg::MTT_W-1:0]            ms_to_ticks;
  logic signed [lrg_pkg::LEVEL_W-1:0]   target_level;
  logic signed [lrg_pkg::LEVEL_W-1:0]   current_level;
  logic signed [lrg_pkg::LEVEL_W-1:0]   step_per_tick;
  logic signed [lrg_pkg::LEVEL_W-1:0]   step_per_sample;
  logic [lrg_pkg::TICK_W-1:0]           ticks_remaining;
  logic                                 retarget_pending;
  logic [lrg_pkg::RAMP_W-1:0]           pending_ramp_time;
  logic                                 ramp_mode;
  logic signed [lrg_pkg::LEVEL_W-1:0]   level_out;
  logic [lrg_pkg::IDX_W-1:0]            sample_idx;

  logic                                 req_fire;
  logic                                 res_fire;
  logic                                 last_sample;
  logic [lrg_pkg::PROD_W-1:0]           product;
  logic [lrg_pkg::TICK_W-1:0]           ticks_new;
  logic signed [lrg_pkg::LEVEL_W:0]     diff;
  logic                                 diff_neg;
  logic [lrg_pkg::DIVD_W-1:0]           diff_mag;
  logic                                 div_start;
  logic [lrg_pkg::DIVD_W-1:0]           div_quot;
  lrg_pkg::div_stat_t                   div_stat;
  logic signed [lrg_pkg::LEVEL_W-1:0]   spt_val;

  assign req_fire    = request.valid && request.ready;
  assign res_fire    = result.valid && result.ready;
  assign last_sample = (sample_idx == lrg_pkg::IDX_W'(lrg_pkg::BLOCK_SIZE - 1));

  // Tick count from ramp time: Q16.8 times Q8.16, keep the integer part, at least one.
  always_comb begin
    product   = {{lrg_pkg::MTT_W{1'b0}}, pending_ramp_time} *
                {{lrg_pkg::RAMP_W{1'b0}}, ms_to_ticks};
    ticks_new = product[lrg_pkg::PROD_W-1:lrg_pkg::MTT_W];
    if (ticks_new == '0) begin
      ticks_new = lrg_pkg::TICK_W'(1);
    end
  end

  // Level difference split into sign and magnitude for the unsigned divider.
  always_comb begin
    diff     = {target_level[lrg_pkg::LEVEL_W-1], target_level} -
               {current_level[lrg_pkg::LEVEL_W-1], current_level};
    diff_neg = diff[lrg_pkg::LEVEL_W];
    diff_mag = diff_neg ? lrg_pkg::DIVD_W'(-diff) : lrg_pkg::DIVD_W'(diff);
  end

  // Signed, saturated per-tick step from the quotient magnitude.
  always_comb begin
    if (!diff_neg) begin
      if (div_quot[lrg_pkg::DIVD_W-1:lrg_pkg::LEVEL_W-1] != '0) begin
        spt_val = lrg_pkg::LEVEL_MAX;
      end else begin
        spt_val = div_quot[lrg_pkg::LEVEL_W-1:0];
      end
    end else begin
      if (div_quot > {2'b01, {(lrg_pkg::LEVEL_W-1){1'b0}}}) begin
        spt_val = lrg_pkg::LEVEL_MIN;
      end else begin
        spt_val = -div_quot[lrg_pkg::LEVEL_W-1:0];
      end
    end
  end

  lrg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (ticks_remaining),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      lrg_pkg::S_IDLE: begin
        if (req_fire && (request.action == lrg_pkg::ACT_TICK)) begin
          state_next = retarget_pending ? lrg_pkg::S_MUL : lrg_pkg::S_EMIT;
        end
      end
      lrg_pkg::S_MUL:       state_next = lrg_pkg::S_DIV_START;
      lrg_pkg::S_DIV_START: state_next = lrg_pkg::S_DIV_WAIT;
      lrg_pkg::S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = lrg_pkg::S_EMIT;
        end
      end
      lrg_pkg::S_EMIT: begin
        if (res_fire && last_sample) begin
          state_next = lrg_pkg::S_IDLE;
        end
      end
      default: state_next = lrg_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    request.ready = (state == lrg_pkg::S_IDLE);
    result.valid  = (state == lrg_pkg::S_EMIT);
    div_start     = (state == lrg_pkg::S_DIV_START);
  end

  assign result.sample = level_out;
  assign result.last   = last_sample;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_to_ticks <= lrg_pkg::MS_TO_TICKS_RESET;
    end else if (cfg_we) begin
      ms_to_ticks <= cfg_wdata;
    end
  end

  // Ramp state, sequencer and sample counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= lrg_pkg::S_IDLE;
      target_level      <= '0;
      current_level     <= '0;
      step_per_tick     <= '0;
      step_per_sample   <= '0;
      ticks_remaining   <= '0;
      retarget_pending  <= 1'b0;
      pending_ramp_time <= '0;
      ramp_mode         <= 1'b0;
      level_out         <= '0;
      sample_idx        <= '0;
    end else begin
      state <= state_next;
      case (state)
        lrg_pkg::S_IDLE: begin
          if (req_fire) begin
            case (request.action)
              lrg_pkg::ACT_SET: begin
                target_level <= request.target_value;
                if (request.ramp_time == '0) begin
                  current_level    <= request.target_value;
                  ticks_remaining  <= '0;
                  retarget_pending <= 1'b0;
                end else begin
                  retarget_pending  <= 1'b1;
                  pending_ramp_time <= request.ramp_time;
                end
              end
              lrg_pkg::ACT_STOP: begin
                target_level     <= current_level;
                ticks_remaining  <= '0;
                retarget_pending <= 1'b0;
              end
              lrg_pkg::ACT_TICK: begin
                sample_idx <= '0;
                ramp_mode  <= (ticks_remaining != '0);
                level_out  <= (ticks_remaining != '0) ? current_level : target_level;
              end
              default: ;
            endcase
          end
        end
        lrg_pkg::S_MUL: begin
          ticks_remaining <= ticks_new;
        end
        lrg_pkg::S_DIV_WAIT: begin
          if (div_stat.done) begin
            step_per_tick    <= spt_val;
            step_per_sample  <= spt_val >>> lrg_pkg::BLOCK_SHIFT;
            retarget_pending <= 1'b0;
            ramp_mode        <= 1'b1;
            level_out        <= current_level;
          end
        end
        lrg_pkg::S_EMIT: begin
          if (res_fire) begin
            if (ramp_mode) begin
              level_out <= lrg_pkg::sat_add(level_out, step_per_sample);
            end
            if (last_sample) begin
              sample_idx <= '0;
              if (ramp_mode) begin
                current_level   <= lrg_pkg::sat_add(current_level, step_per_tick);
                ticks_remaining <= ticks_remaining - 1'b1;
              end else begin
                current_level <= target_level;
              end
            end else begin
              sample_idx <= sample_idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_one_side, result.valid && request.ready,
                "request taken while a block is being emitted")
  `ASSERT_PROP(a_block_end, (res_fire && last_sample) |=> request.ready,
               "block did not return to idle after its last sample")
  `ASSERT_NEVER(a_ramp_ticks, result.valid && ramp_mode && (ticks_remaining == '0),
                "ramp block emitted with no ticks remaining")

endmodule

// File: test/tb.sv
// Self-checking testbench of the linear ramp generator: directed and random requests.
`timescale 1ns / 1ps

module tb;
  import lrg_pkg::*;

  localparam logic [1:0]        ACT_UNUSED  = 2'd3;
  localparam int                CYCLE_LIMIT = 1000000;
  localparam int                DRAIN_GAP   = 150;
  localparam int                LONG_STALL  = 400;
  localparam int                IDLE_PCT    = 9;
  localparam int                MAX_REPORTS = 100;
  localparam logic [MTT_W-1:0]  MTT_MAX     = '1;
  localparam logic [RAMP_W-1:0] RAMP_MAX    = '1;

  typedef struct {
    logic [1:0]                action;
    logic signed [LEVEL_W-1:0] target;
    logic [RAMP_W-1:0]         ramp;
  } ramp_request_t;

  typedef struct {
    logic signed [LEVEL_W-1:0] level;
    logic                      last;
  } block_sample_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [MTT_W-1:0]  cfg_wdata;

  lrg_in_if  req_if ();
  lrg_out_if res_if ();

  linear_ramp_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (req_if),
    .result    (res_if)
  );

  // Requests still to be offered, and the samples the ramp should produce.
  ramp_request_t pending_requests[$];
  block_sample_t expected_samples[$];

  // Own copy of the ramp state and of the ticks-per-millisecond register.
  logic [MTT_W-1:0]          ticks_per_ms   = MS_TO_TICKS_RESET;
  logic signed [LEVEL_W-1:0] lvl_target     = '0;
  logic signed [LEVEL_W-1:0] lvl_current    = '0;
  logic signed [LEVEL_W-1:0] step_tick      = '0;
  logic signed [LEVEL_W-1:0] step_sample    = '0;
  logic [TICK_W-1:0]         ticks_left     = '0;
  logic                      retarget_armed = 1'b0;
  logic [RAMP_W-1:0]         armed_ramp     = '0;

  int          mismatches        = 0;
  int          samples_checked   = 0;
  int          requests_accepted = 0;
  int          ticks_accepted    = 0;
  int unsigned cycle_count       = 0;
  logic        request_taken     = 1'b0;
  int          stall_left        = 0;
  bit          stall_done        = 1'b0;
  logic        calm;

  // A window of the run in which neither side idles.
  assign calm = (cycle_count >= 6000) && (cycle_count < 12000);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Level saturated to the signed Q16.16 range.
  function automatic logic signed [LEVEL_W-1:0] clamp_level(input longint v);
    if (v > longint'(LEVEL_MAX)) return LEVEL_MAX;
    if (v < longint'(LEVEL_MIN)) return LEVEL_MIN;
    return v[LEVEL_W-1:0];
  endfunction

  // Updates the ramp state for one accepted request and queues its samples.
  task automatic predict_ramp(input ramp_request_t r);
    longint unsigned prod;
    longint          n_ticks;
    longint          diff;
    logic signed [LEVEL_W-1:0] lvl;
    block_sample_t   s;
    case (r.action)
      ACT_SET: begin
        lvl_target = r.target;
        if (r.ramp == '0) begin
          lvl_current    = r.target;
          ticks_left     = '0;
          retarget_armed = 1'b0;
        end else begin
          retarget_armed = 1'b1;
          armed_ramp     = r.ramp;
        end
      end
      ACT_STOP: begin
        lvl_target     = lvl_current;
        ticks_left     = '0;
        retarget_armed = 1'b0;
      end
      ACT_TICK: begin
        // A pending retarget is resolved into a tick count and two steps.
        if (retarget_armed) begin
          prod    = longint'(armed_ramp) * longint'(ticks_per_ms);
          n_ticks = longint'(prod >> 24);
          if (n_ticks < 1) n_ticks = 1;
          if (n_ticks > 64'hFF_FFFF) n_ticks = 64'hFF_FFFF;
          ticks_left     = n_ticks[TICK_W-1:0];
          diff           = longint'(lvl_target) - longint'(lvl_current);
          step_tick      = clamp_level(diff / n_ticks);
          step_sample    = step_tick >>> BLOCK_SHIFT;
          retarget_armed = 1'b0;
        end
        if (ticks_left != '0) begin
          lvl = lvl_current;
          for (int i = 0; i < BLOCK_SIZE; i++) begin
            s.level = lvl;
            s.last  = (i == BLOCK_SIZE - 1);
            expected_samples.push_back(s);
            lvl = clamp_level(longint'(lvl) + longint'(step_sample));
          end
          lvl_current = clamp_level(longint'(lvl_current) + longint'(step_tick));
          ticks_left  = ticks_left - 1'b1;
        end else begin
          for (int i = 0; i < BLOCK_SIZE; i++) begin
            s.level = lvl_target;
            s.last  = (i == BLOCK_SIZE - 1);
            expected_samples.push_back(s);
          end
          lvl_current = lvl_target;
        end
      end
      default: begin
        // The unused action code leaves everything as it is.
      end
    endcase
  endtask

  task automatic push_request(input logic [1:0] action, input logic signed [LEVEL_W-1:0] target,
                              input logic [RAMP_W-1:0] ramp);
    ramp_request_t r;
    r.action = action;
    r.target = target;
    r.ramp   = ramp;
    pending_requests.push_back(r);
  endtask

  // Mostly a set followed by enough ticks to finish the ramp, with some noise.
  task automatic queue_random_requests(input int n);
    int              made;
    int              want;
    int              runs;
    longint unsigned span;
    logic signed [LEVEL_W-1:0] tgt;
    logic [RAMP_W-1:0] ramp;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 15) begin
        push_request(2'($urandom_range(0, 3)), $urandom, RAMP_W'($urandom));
        if (pending_requests[$].action != ACT_UNUSED) made++;
      end else begin
        case ($urandom_range(0, 5))
          0:       tgt = LEVEL_MAX;
          1:       tgt = LEVEL_MIN;
          2:       tgt = $signed($urandom_range(0, 2000)) - 1000;
          default: tgt = $urandom;
        endcase
        case ($urandom_range(0, 3))
          0: begin
            ramp = '0;
            want = 1;
          end
          1: begin
            ramp = RAMP_W'($urandom);
            want = $urandom_range(1, 4);
          end
          default: begin
            want = $urandom_range(1, 6);
            if (ticks_per_ms == '0) begin
              ramp = RAMP_W'($urandom);
            end else begin
              span = ((longint'(want) << 24) + ticks_per_ms - 1) / ticks_per_ms
                     + $urandom_range(0, 2);
              ramp = (span > RAMP_MAX) ? RAMP_MAX : span[RAMP_W-1:0];
            end
          end
        endcase
        push_request(ACT_SET, tgt, ramp);
        made++;
        runs = want + $urandom_range(0, 2);
        for (int k = 0; k < runs; k++) begin
          if (k > 0 && $urandom_range(0, 99) < 8) begin
            push_request(ACT_STOP, $urandom, RAMP_W'($urandom));
            made++;
          end
          push_request(ACT_TICK, $urandom, RAMP_W'($urandom));
          made++;
        end
      end
    end
  endtask

  // Waits until every request is taken and every sample has arrived.
  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || req_if.valid || expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_ticks_per_ms(input logic [MTT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we       <= 1'b0;
    ticks_per_ms = value;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // Accepted requests are fed to the predictor at the edge that takes them.
  always @(posedge clk) begin : accept_requests
    ramp_request_t seen;
    request_taken <= !rst && req_if.valid && req_if.ready;
    if (!rst && req_if.valid && req_if.ready) begin
      seen.action = req_if.action;
      seen.target = req_if.target_value;
      seen.ramp   = req_if.ramp_time;
      predict_ramp(seen);
      requests_accepted++;
      if (seen.action == ACT_TICK) ticks_accepted++;
    end
  end

  // Request driver: offers the next pending request, idling now and then.
  always @(negedge clk) begin : drive_requests
    ramp_request_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || request_taken) begin
      if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_requests.pop_front();
        req_if.valid        <= 1'b1;
        req_if.action       <= nxt.action;
        req_if.target_value <= nxt.target;
        req_if.ramp_time    <= nxt.ramp;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off once the run is under way.
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!stall_done && samples_checked >= 1500) begin
      stall_done   <= 1'b1;
      stall_left   <= LONG_STALL;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Each sample taken is compared with the oldest expected one.
  always @(posedge clk) begin : check_samples
    block_sample_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      samples_checked++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $error("unexpected sample %0d (last %0b) with no block pending",
                 res_if.sample, res_if.last);
        end
      end else begin
        want = expected_samples.pop_front();
        if (res_if.sample !== want.level) report_mismatch("sample", want.level, res_if.sample);
        if (res_if.last !== want.last) report_mismatch("last", want.last, res_if.last);
      end
    end
  end

  // Safety net against a hung block.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL linear_ramp_generator");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_if.valid        = 1'b0;
    req_if.action       = ACT_SET;
    req_if.target_value = '0;
    req_if.ramp_time    = '0;
    res_if.ready        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: flat output from reset, jumps, extreme targets and ramps.
    push_request(ACT_TICK, '0, '0);
    push_request(ACT_SET, LEVEL_MAX, '0);
    push_request(ACT_TICK, '0, '0);
    // A one-tick ramp across the full range saturates the step.
    push_request(ACT_SET, LEVEL_MIN, 24'd1);
    push_request(ACT_TICK, '0, '0);
    push_request(ACT_TICK, '0, '0);
    // The longest ramp, stopped part way through.
    push_request(ACT_SET, LEVEL_MAX, RAMP_MAX);
    push_request(ACT_TICK, '0, '0);
    push_request(ACT_TICK, LEVEL_MIN, RAMP_MAX);
    push_request(ACT_STOP, LEVEL_MAX, RAMP_MAX);
    push_request(ACT_TICK, '0, '0);
    // The unused action code must be ignored.
    push_request(ACT_UNUSED, 32'sd99999, 24'd256);
    push_request(ACT_TICK, '0, '0);
    push_request(ACT_SET, 32'sd12345, 24'd74240);
    push_request(ACT_TICK, '0, '0);
    push_request(ACT_TICK, '0, '0);
    // A jump overrides an armed retarget.
    push_request(ACT_SET, -32'sd5000, 24'd74240);
    push_request(ACT_SET, 32'sd777, '0);
    push_request(ACT_TICK, '0, '0);
    // A stop cancels an armed retarget.
    push_request(ACT_SET, 32'sh4000_0000, 24'd74240);
    push_request(ACT_STOP, '0, '0);
    push_request(ACT_TICK, '0, '0);
    push_request(ACT_SET, -32'sd1, 24'd300000);
    push_request(ACT_TICK, '0, '0);
    push_request(ACT_TICK, '0, '0);
    wait_until_drained();

    // Random phases over several register settings.
    queue_random_requests(90);
    wait_until_drained();
    write_ticks_per_ms('0);
    queue_random_requests(85);
    wait_until_drained();
    write_ticks_per_ms(MTT_MAX);
    queue_random_requests(85);
    wait_until_drained();
    write_ticks_per_ms(MTT_W'($urandom_range(1, 16777214)));
    queue_random_requests(95);
    wait_until_drained();

    $display("Checked %0d samples from %0d ticks among %0d accepted requests.",
             samples_checked, ticks_accepted, requests_accepted);
    $display("Ticks per ms covered the reset value, zero, full scale and one random setting.");
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("PASS linear_ramp_generator");
    end else begin
      $display("FAIL linear_ramp_generator");
    end
    $finish;
  end

endmodule
